@@ src/vpii_pkg.sv @@
// ----------------------------------------------------------------------------
// vpii_pkg
// Shared widths, codes and controller/datapath interface types for the
// value position inverted index.
// ----------------------------------------------------------------------------
package vpii_pkg;

   localparam int DEFAULT_MAX_ITEMS = 64;
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACK          = 3'd0,
      ST_OUT_OF_RANGE = 3'd1,
      ST_EMPTY        = 3'd2,
      ST_POSITION     = 3'd3,
      ST_FULL         = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;        // capture the request
      logic       clear;        // empty the list
      logic       append;       // store the held value
      logic       scan_start;   // restart scan at position zero
      logic       scan_next;    // advance scan position
      logic       pend_load;    // hold current scan position as pending match
      logic       emit;         // load the result register
      status_type emit_status;
      logic       emit_last;
      logic       emit_pend;    // result position comes from pending match
   } dp_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             out_free;
      logic             full;
      logic             in_range;
      logic             match;
      logic             scan_last;
      logic             pend_valid;
   } dp_sts_type;

endpackage

@@ src/vpii_ram.sv @@
// ----------------------------------------------------------------------------
// vpii_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module vpii_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/vpii_datapath.sv @@
// ----------------------------------------------------------------------------
// vpii_datapath
// Value store, count and bounds registers, scan position, pending match and
// the result register.
// ----------------------------------------------------------------------------
module vpii_datapath import vpii_pkg::*; #(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [VALUE_W-1:0]  req_item_value,
   input  dp_ctl_type                 ctl,
   output dp_sts_type                 sts,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_position,
   output logic                       rsp_last,
   output logic [COUNT_W-1:0]         rsp_item_count,
   output logic signed [VALUE_W-1:0]  rsp_low_bound,
   output logic signed [VALUE_W-1:0]  rsp_high_bound
);

   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   logic [CMD_W-1:0]          cmd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic [AW-1:0]             idx_ff;
   logic [AW-1:0]             pend_pos_ff;
   logic                      pend_valid_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic                      rsp_last_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [VALUE_W-1:0] rsp_low_ff;
   logic signed [VALUE_W-1:0] rsp_high_ff;
   logic [VALUE_W-1:0]        rd_data;
   logic                      out_free;

   vpii_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.append),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // next count and bounds
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (ctl.clear) begin
         count_in = '0;
         min_in   = '0;
         max_in   = '0;
      end else if (ctl.append) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            min_in = value_ff;
            max_in = value_ff;
         end else begin
            if (value_ff < min_ff) begin
               min_in = value_ff;
            end
            if (value_ff > max_ff) begin
               max_in = value_ff;
            end
         end
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = ctl.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.scan_start) begin
            pend_valid_ff <= 1'b0;
         end else if (ctl.pend_load) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff   <= req_command;
         value_ff <= req_item_value;
      end
      if (ctl.scan_start) begin
         idx_ff <= '0;
      end else if (ctl.scan_next) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (ctl.pend_load) begin
         pend_pos_ff <= idx_ff;
      end
      if (ctl.emit) begin
         rsp_status_ff <= ctl.emit_status;
         rsp_pos_ff    <= ctl.emit_pend ? POS_W'(pend_pos_ff) : '0;
         rsp_last_ff   <= ctl.emit_last;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_low_ff    <= min_in;
         rsp_high_ff   <= max_in;
      end
   end

   assign sts.cmd        = cmd_ff;
   assign sts.out_free   = out_free;
   assign sts.full       = (count_ff == CNT_W'(MAX_ITEMS));
   assign sts.in_range   = (count_ff != '0) && (value_ff >= min_ff) && (value_ff <= max_ff);
   assign sts.match      = (rd_data == value_ff);
   assign sts.scan_last  = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
   assign sts.pend_valid = pend_valid_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_item_count = rsp_count_ff;
   assign rsp_low_bound  = rsp_low_ff;
   assign rsp_high_bound = rsp_high_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("stored count exceeds capacity");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("low bound above high bound");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> out_free)
      else $error("result overwritten before transfer");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ctl.append |-> (count_ff < CNT_W'(MAX_ITEMS)))
      else $error("append into a full store");

endmodule

@@ src/vpii_ctrl.sv @@
// ----------------------------------------------------------------------------
// vpii_ctrl
// Command sequencer: takes a request, runs clear, append or the query scan,
// and schedules each result into the result register.
// ----------------------------------------------------------------------------
module vpii_ctrl import vpii_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_READ  = 5'b00100,
      S_CMP   = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.cmd)
               CMD_CLEAR: begin
                  if (sts.out_free) begin
                     ctl.clear       = 1'b1;
                     ctl.emit        = 1'b1;
                     ctl.emit_status = ST_ACK;
                     ctl.emit_last   = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               CMD_APPEND: begin
                  if (sts.out_free) begin
                     ctl.append      = !sts.full;
                     ctl.emit        = 1'b1;
                     ctl.emit_status = sts.full ? ST_FULL : ST_ACK;
                     ctl.emit_last   = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               CMD_QUERY: begin
                  if (!sts.in_range) begin
                     if (sts.out_free) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_OUT_OF_RANGE;
                        ctl.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     ctl.scan_start = 1'b1;
                     state_in       = S_READ;
                  end
               end
               default: begin
                  // unused code: drop
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.match && sts.pend_valid && !sts.out_free) begin
               // hold until the previous match can move out
               state_in = S_CMP;
            end else begin
               if (sts.match) begin
                  ctl.pend_load = 1'b1;
                  if (sts.pend_valid) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_status = ST_POSITION;
                     ctl.emit_pend   = 1'b1;
                  end
               end
               if (sts.scan_last) begin
                  state_in = S_FLUSH;
               end else begin
                  ctl.scan_next = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_last   = 1'b1;
               ctl.emit_pend   = sts.pend_valid;
               ctl.emit_status = sts.pend_valid ? ST_POSITION : ST_EMPTY;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> sts.in_range)
      else $error("scan running on a list that is out of range");

   a_flush_single: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.emit_status == ST_EMPTY) |-> !sts.pend_valid)
      else $error("empty reported with a match pending");

   a_position_pend: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.emit_status == ST_POSITION) |-> sts.pend_valid)
      else $error("position emitted without a pending match");

endmodule

@@ src/value_position_inverted_index.sv @@
// ----------------------------------------------------------------------------
// value_position_inverted_index
// Inverted list of appended signed values: clear, append, query positions.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_ready, req_command, req_item_value) takes
//    one command per transfer: clear, append a value, or query a value.
//  - Result channel (rsp_valid/rsp_ready) returns status, position, last,
//    item count and the low/high bounds; the final result of a command has
//    rsp_last set. Clear and append give one result, a query gives one result
//    per matching position in ascending order, or one out-of-range or empty
//    result. Unused command codes give no result.
//  - Clear and append put their result straight into the result register.
//    A query scans the store: the value store is one RAM with a single
//    registered read port, and each stored entry is read and then compared.
//    A new request is taken once the previous one is done.
//  - A match is held pending so that the last flag can be set on the final
//    one; the scan pauses on a new match, with one pending, while the result
//    register is full and not taken.
//  - Reset empties the list (count and bounds to zero); stored values are not
//    cleared, since only entries below the count are ever read.
//  - A stall on the result side holds the result register and, in turn, the
//    sequencer; no result is lost or repeated.
// ----------------------------------------------------------------------------
module value_position_inverted_index import vpii_pkg::*; #(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_last,
   output logic [COUNT_W-1:0]        rsp_item_count,
   output logic signed [VALUE_W-1:0] rsp_low_bound,
   output logic signed [VALUE_W-1:0] rsp_high_bound
);

   dp_ctl_type ctl;
   dp_sts_type sts;

   // sequencer: one command at a time
   vpii_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // store, bounds, scan and result register
   vpii_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_item_value (req_item_value),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_item_count (rsp_item_count),
      .rsp_low_bound  (rsp_low_bound),
      .rsp_high_bound (rsp_high_bound)
   );

endmodule
